// ===== src/sae_pkg.sv =====
// ----------------------------------------------------------------------------
// sae_pkg
// Shared types and constants for the data-processing execute pipeline.
// ----------------------------------------------------------------------------
package sae_pkg;

	// Instruction class field, bits 27..25
	localparam logic [2:0] CLS_REG = 3'b000;
	localparam logic [2:0] CLS_IMM = 3'b001;

	// Register number of the program counter
	localparam logic [3:0] REG_PC = 4'hF;

	// Largest shift the shifter needs to see
	localparam logic [5:0] SHIFT_FULL = 6'd32;

	// Status codes
	localparam logic [1:0] STAT_DONE   = 2'd0;
	localparam logic [1:0] STAT_UNDEF  = 2'd1;
	localparam logic [1:0] STAT_UNPRED = 2'd2;

	// Shift type field, bits 6..5
	localparam logic [1:0] SHT_LSL = 2'd0;
	localparam logic [1:0] SHT_LSR = 2'd1;
	localparam logic [1:0] SHT_ASR = 2'd2;
	localparam logic [1:0] SHT_ROR = 2'd3;

	// ALU opcode, bits 24..21
	typedef enum logic [3:0] {
		OP_AND = 4'h0, OP_EOR = 4'h1, OP_SUB = 4'h2, OP_RSB = 4'h3,
		OP_ADD = 4'h4, OP_ADC = 4'h5, OP_SBC = 4'h6, OP_RSC = 4'h7,
		OP_TST = 4'h8, OP_TEQ = 4'h9, OP_CMP = 4'hA, OP_CMN = 4'hB,
		OP_ORR = 4'hC, OP_MOV = 4'hD, OP_BIC = 4'hE, OP_MVN = 4'hF
	} alu_op_t;

	// Normalized shifter operation, decided in the decode stage
	typedef enum logic [2:0] {
		SH_PASS = 3'd0, // operand as is, carry from flags
		SH_LSL  = 3'd1, // amount 1..32
		SH_LSR  = 3'd2, // amount 1..32
		SH_ASR  = 3'd3, // amount 1..32
		SH_ROR  = 3'd4, // amount taken mod 32, carry is result bit 31
		SH_RRX  = 3'd5,
		SH_ZERO = 3'd6  // zero with carry 0
	} shift_kind_t;

	// Write-back and status controls, fixed at decode
	typedef struct packed {
		logic [3:0] dest_index;
		logic       dest_write;
		logic       flags_write;
		logic       restore_status;
		logic [1:0] status;
	} ctrl_t;

	// Decode to shifter stage
	typedef struct packed {
		shift_kind_t kind;
		logic [5:0]  amount;
		logic [31:0] operand;
		logic [31:0] first_value;
		alu_op_t     op;
		logic [3:0]  flags;
		logic        bad;
		ctrl_t       ctrl;
	} dec_t;

	// Shifter to ALU stage
	typedef struct packed {
		logic [31:0] operand;
		logic        shift_carry;
		logic [31:0] first_value;
		alu_op_t     op;
		logic [3:0]  flags;
		logic        bad;
		ctrl_t       ctrl;
	} shf_t;

endpackage

// ===== src/shifter_alu_execute_top.sv =====
// ----------------------------------------------------------------------------
// shifter_alu_execute_top
// Data-processing execute unit: shifter operand, ALU and flag update.
// ----------------------------------------------------------------------------
// Three-stage pipeline (decode, barrel shift, ALU). An item is taken on any
// cycle with start high; busy is always low, so one item enters every cycle.
// Its result passes the decode, shift and ALU registers and appears with done high for one cycle.
// The receiver cannot stall the unit and must take each result when done is
// high. The result ports hold meaningless data when done is low. No state is
// kept between items and nothing needs initializing after reset.
module shifter_alu_execute_top import sae_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] instr,
	input  logic [31:0] first_value,
	input  logic [31:0] shifted_value,
	input  logic [31:0] amount_value,
	input  logic [3:0]  flags_in,
	input  logic        has_saved_status,
	output logic        done,
	output logic [31:0] result_value,
	output logic [3:0]  dest_index,
	output logic        dest_write,
	output logic [3:0]  flags_out,
	output logic        flags_write,
	output logic        restore_status,
	output logic [1:0]  status
);

	logic  valid_s1;
	logic  valid_s2;
	logic  valid_s3;
	dec_t  dec_s1;
	shf_t  shf_s2;
	ctrl_t ctrl_s3;

	// Pipeline never stalls
	assign busy = 1'b0;

	sae_decode u_decode (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (start && !busy),
		.instr            (instr),
		.first_value      (first_value),
		.shifted_value    (shifted_value),
		.amount_value     (amount_value),
		.flags_in         (flags_in),
		.has_saved_status (has_saved_status),
		.valid_s1         (valid_s1),
		.dec_s1           (dec_s1)
	);

	sae_shift u_shift (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1),
		.valid_s2 (valid_s2),
		.shf_s2   (shf_s2)
	);

	sae_alu u_alu (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.shf_s2    (shf_s2),
		.valid_s3  (valid_s3),
		.result_s3 (result_value),
		.flags_s3  (flags_out),
		.ctrl_s3   (ctrl_s3)
	);

	// Result ports
	assign done           = valid_s3;
	assign dest_index     = ctrl_s3.dest_index;
	assign dest_write     = ctrl_s3.dest_write;
	assign flags_write    = ctrl_s3.flags_write;
	assign restore_status = ctrl_s3.restore_status;
	assign status         = ctrl_s3.status;

	// Every item comes out after a fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##3 done)
		else $error("item did not complete in three cycles");

	// An undefined instruction writes nothing and reports all zero
	a_undef_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STAT_UNDEF) |->
		(result_value == 32'd0) && !dest_write && !flags_write && !restore_status)
		else $error("undefined instruction with side effects");

	// Status restore only on a PC destination and never with a flag write
	a_restore: assert property (@(posedge clk) disable iff (!arst_n)
		done && restore_status |-> !flags_write && (dest_index == REG_PC))
		else $error("status restore with flag write or wrong destination");

	// Compare and test operations always update the flags
	a_cmp_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done && !dest_write && (status == STAT_DONE) |-> flags_write)
		else $error("compare without flag write");

endmodule

// ===== src/sae_decode.sv =====
// ----------------------------------------------------------------------------
// sae_decode
// Stage 1: classifies the instruction, picks the shifter source and reduces
// every shift form to one normalized shifter operation and amount.
// ----------------------------------------------------------------------------
module sae_decode import sae_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] instr,
	input  logic [31:0] first_value,
	input  logic [31:0] shifted_value,
	input  logic [31:0] amount_value,
	input  logic [3:0]  flags_in,
	input  logic        has_saved_status,
	output logic        valid_s1,
	output dec_t        dec_s1
);

	dec_t dec_d;

	// Instruction fields
	logic [2:0] cls;
	logic       sbit;
	logic [3:0] rd;
	logic       is_cmp;
	logic       pc_write_s;
	logic [4:0] rot;
	logic [4:0] imm_sh;
	logic [7:0] reg_sh;
	logic [1:0] sh_type;

	assign cls        = instr[27:25];
	assign sbit       = instr[20];
	assign rd         = instr[15:12];
	assign is_cmp     = (instr[24:23] == 2'b10);
	assign pc_write_s = !is_cmp && sbit && (rd == REG_PC);
	assign rot        = {instr[11:8], 1'b0};
	assign imm_sh     = instr[11:7];
	assign reg_sh     = amount_value[7:0];
	assign sh_type    = instr[6:5];

	// Control, special cases and shifter operation
	always_comb begin
		dec_d.op          = alu_op_t'(instr[24:21]);
		dec_d.flags       = flags_in;
		dec_d.first_value = first_value;
		dec_d.bad         = !(cls == CLS_REG || cls == CLS_IMM) || (is_cmp && !sbit);
		if (dec_d.bad) begin
			dec_d.ctrl = '0;
			dec_d.ctrl.status = STAT_UNDEF;
		end else begin
			dec_d.ctrl.dest_index     = rd;
			dec_d.ctrl.dest_write     = !is_cmp;
			dec_d.ctrl.flags_write    = is_cmp || (sbit && (rd != REG_PC));
			dec_d.ctrl.restore_status = pc_write_s && has_saved_status;
			dec_d.ctrl.status         = (pc_write_s && !has_saved_status) ?
				STAT_UNPRED : STAT_DONE;
		end

		// Shifter operation
		dec_d.kind    = SH_PASS;
		dec_d.amount  = '0;
		dec_d.operand = shifted_value;
		if (instr[25]) begin
			// rotated immediate: rotate by zero keeps the flag carry
			dec_d.operand = {24'd0, instr[7:0]};
			dec_d.kind    = (rot == 5'd0) ? SH_PASS : SH_ROR;
			dec_d.amount  = {1'b0, rot};
		end else if (!instr[4]) begin
			// immediate amount: zero encodes LSR/ASR by 32 and RRX
			unique case (sh_type)
				SHT_LSL: begin
					dec_d.kind   = (imm_sh == 5'd0) ? SH_PASS : SH_LSL;
					dec_d.amount = {1'b0, imm_sh};
				end
				SHT_LSR: begin
					dec_d.kind   = SH_LSR;
					dec_d.amount = (imm_sh == 5'd0) ? SHIFT_FULL : {1'b0, imm_sh};
				end
				SHT_ASR: begin
					dec_d.kind   = SH_ASR;
					dec_d.amount = (imm_sh == 5'd0) ? SHIFT_FULL : {1'b0, imm_sh};
				end
				SHT_ROR: begin
					dec_d.kind   = (imm_sh == 5'd0) ? SH_RRX : SH_ROR;
					dec_d.amount = {1'b0, imm_sh};
				end
				default: begin
					dec_d.kind = SH_PASS;
				end
			endcase
		end else if (reg_sh != 8'd0) begin
			// register amount, low byte only
			unique case (sh_type)
				SHT_LSL: begin
					dec_d.kind   = (reg_sh > 8'd32) ? SH_ZERO : SH_LSL;
					dec_d.amount = reg_sh[5:0];
				end
				SHT_LSR: begin
					dec_d.kind   = (reg_sh > 8'd32) ? SH_ZERO : SH_LSR;
					dec_d.amount = reg_sh[5:0];
				end
				SHT_ASR: begin
					dec_d.kind   = SH_ASR;
					dec_d.amount = (reg_sh >= 8'd32) ? SHIFT_FULL : reg_sh[5:0];
				end
				SHT_ROR: begin
					dec_d.kind   = SH_ROR;
					dec_d.amount = {1'b0, reg_sh[4:0]};
				end
				default: begin
					dec_d.kind = SH_PASS;
				end
			endcase
		end
	end

	// Stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		dec_s1 <= dec_d;
	end

endmodule

// ===== src/sae_shift.sv =====
// ----------------------------------------------------------------------------
// sae_shift
// Stage 2: barrel shifter producing the second ALU operand and its carry.
// ----------------------------------------------------------------------------
module sae_shift import sae_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_s1,
	input  dec_t dec_s1,
	output logic valid_s2,
	output shf_t shf_s2
);

	shf_t               shf_d;
	logic        [63:0] lsl_w;
	logic        [63:0] lsr_w;
	logic signed [63:0] asr_w;
	logic        [63:0] ror_w;
	logic        [31:0] rm;

	assign rm    = dec_s1.operand;
	// carry lands in the bit next to the kept word
	assign lsl_w = {32'd0, rm} << dec_s1.amount;
	assign lsr_w = {rm, 32'd0} >> dec_s1.amount;
	assign asr_w = $signed({rm, 32'd0}) >>> dec_s1.amount;
	assign ror_w = {rm, rm} >> dec_s1.amount[4:0];

	always_comb begin
		shf_d.first_value = dec_s1.first_value;
		shf_d.op          = dec_s1.op;
		shf_d.flags       = dec_s1.flags;
		shf_d.bad         = dec_s1.bad;
		shf_d.ctrl        = dec_s1.ctrl;
		unique case (dec_s1.kind)
			SH_PASS: begin
				shf_d.operand     = rm;
				shf_d.shift_carry = dec_s1.flags[1];
			end
			SH_LSL: begin
				shf_d.operand     = lsl_w[31:0];
				shf_d.shift_carry = lsl_w[32];
			end
			SH_LSR: begin
				shf_d.operand     = lsr_w[63:32];
				shf_d.shift_carry = lsr_w[31];
			end
			SH_ASR: begin
				shf_d.operand     = asr_w[63:32];
				shf_d.shift_carry = asr_w[31];
			end
			SH_ROR: begin
				shf_d.operand     = ror_w[31:0];
				shf_d.shift_carry = ror_w[31];
			end
			SH_RRX: begin
				shf_d.operand     = {dec_s1.flags[1], rm[31:1]};
				shf_d.shift_carry = rm[0];
			end
			SH_ZERO: begin
				shf_d.operand     = '0;
				shf_d.shift_carry = 1'b0;
			end
			default: begin
				shf_d.operand     = rm;
				shf_d.shift_carry = dec_s1.flags[1];
			end
		endcase
	end

	// Stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		shf_s2 <= shf_d;
	end

endmodule

// ===== src/sae_alu.sv =====
// ----------------------------------------------------------------------------
// sae_alu
// Stage 3: 32-bit ALU with NZCV generation, registered at the result ports.
// ----------------------------------------------------------------------------
module sae_alu import sae_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s2,
	input  shf_t        shf_s2,
	output logic        valid_s3,
	output logic [31:0] result_s3,
	output logic [3:0]  flags_s3,
	output ctrl_t       ctrl_s3
);

	logic [31:0] a;
	logic [31:0] b;
	logic        cin;
	logic [31:0] add_x;
	logic [31:0] add_y;
	logic        add_ci;
	logic [32:0] sum;
	logic        add_v;
	logic        arith;
	logic [31:0] res_d;
	logic        c_d;
	logic        v_d;
	logic [3:0]  flags_d;

	assign a   = shf_s2.first_value;
	assign b   = shf_s2.operand;
	assign cin = shf_s2.flags[1];

	// Adder operands per opcode; reverse subtracts swap the order
	always_comb begin
		add_x  = a;
		add_y  = b;
		add_ci = 1'b0;
		arith  = 1'b1;
		unique case (shf_s2.op)
			OP_SUB, OP_CMP: begin
				add_y  = ~b;
				add_ci = 1'b1;
			end
			OP_RSB: begin
				add_x  = b;
				add_y  = ~a;
				add_ci = 1'b1;
			end
			OP_ADD, OP_CMN: begin
				add_ci = 1'b0;
			end
			OP_ADC: begin
				add_ci = cin;
			end
			OP_SBC: begin
				add_y  = ~b;
				add_ci = cin;
			end
			OP_RSC: begin
				add_x  = b;
				add_y  = ~a;
				add_ci = cin;
			end
			OP_AND, OP_EOR, OP_TST, OP_TEQ, OP_ORR, OP_MOV, OP_BIC, OP_MVN: begin
				arith = 1'b0;
			end
			default: begin
				arith = 1'b0;
			end
		endcase
	end

	assign sum   = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_ci};
	assign add_v = ~(add_x[31] ^ add_y[31]) & (add_x[31] ^ sum[31]);

	// Result select
	always_comb begin
		unique case (shf_s2.op)
			OP_AND, OP_TST: res_d = a & b;
			OP_EOR, OP_TEQ: res_d = a ^ b;
			OP_ORR:         res_d = a | b;
			OP_MOV:         res_d = b;
			OP_BIC:         res_d = a & ~b;
			OP_MVN:         res_d = ~b;
			default:        res_d = sum[31:0];
		endcase
	end

	// Logical ops keep V and take C from the shifter
	assign c_d     = arith ? sum[32] : shf_s2.shift_carry;
	assign v_d     = arith ? add_v : shf_s2.flags[0];
	assign flags_d = {res_d[31], (res_d == 32'd0), c_d, v_d};

	// Stage 3 registers, drive the result ports
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		result_s3 <= shf_s2.bad ? 32'd0 : res_d;
		flags_s3  <= shf_s2.bad ? 4'd0 : flags_d;
		ctrl_s3   <= shf_s2.ctrl;
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the data-processing execute unit. A short directed table
// covers the field extremes, every ALU opcode and each shifter and status
// corner. A randomized stream of mostly well-formed instructions follows.
// Typed rows are compared field by field against a hand-written result, all others against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_top import sae_pkg::*; ();

	// One instruction item as driven onto the ports
	typedef struct packed {
		logic [31:0] instr;
		logic [31:0] first_value;
		logic [31:0] shifted_value;
		logic [31:0] amount_value;
		logic [3:0]  flags_in;
		logic        has_saved_status;
	} dp_item_t;

	// One result as seen on the ports
	typedef struct packed {
		logic [31:0] result_value;
		logic [3:0]  dest_index;
		logic        dest_write;
		logic [3:0]  flags_out;
		logic        flags_write;
		logic        restore_status;
		logic [1:0]  status;
	} dp_result_t;

	// Directed table row; typed rows carry a hand-written result
	typedef struct {
		dp_item_t   item;
		bit         typed;
		dp_result_t want;
	} dir_row_t;

	localparam dp_result_t UNDEF_RESULT = '{32'h0, 4'h0, 1'b0, 4'h0, 1'b0, 1'b0, STAT_UNDEF};
	localparam int RANDOM_ITEMS = 750;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [31:0] instr = '0;
	logic [31:0] first_value = '0;
	logic [31:0] shifted_value = '0;
	logic [31:0] amount_value = '0;
	logic [3:0]  flags_in = '0;
	logic        has_saved_status = 1'b0;
	logic        busy;
	logic        done;
	logic [31:0] result_value;
	logic [3:0]  dest_index;
	logic        dest_write;
	logic [3:0]  flags_out;
	logic        flags_write;
	logic        restore_status;
	logic [1:0]  status;

	logic       busy_seen = 1'b1;
	dp_result_t pending_results[$];
	dir_row_t   directed_rows[$];
	int         mismatch_count = 0;

	shifter_alu_execute_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.instr(instr),
		.first_value(first_value),
		.shifted_value(shifted_value),
		.amount_value(amount_value),
		.flags_in(flags_in),
		.has_saved_status(has_saved_status),
		.done(done),
		.result_value(result_value),
		.dest_index(dest_index),
		.dest_write(dest_write),
		.flags_out(flags_out),
		.flags_write(flags_write),
		.restore_status(restore_status),
		.status(status)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
		logic [63:0] t;
		t = {x, x} >> (n % 32);
		return t[31:0];
	endfunction

	// Second ALU operand; returns {shift carry, operand}
	function automatic logic [32:0] barrel_shift(logic [31:0] ins, logic [31:0] rm,
			logic [31:0] rs, logic cin);
		int unsigned n;
		logic [31:0] val;
		logic [1:0]  ty;
		ty = ins[6:5];
		// rotated immediate, rotation is twice the field
		if (ins[25]) begin
			n = 2 * ins[11:8];
			val = ror32({24'h0, ins[7:0]}, n);
			return {(n == 0) ? cin : val[31], val};
		end
		// shift by immediate amount
		if (!ins[4]) begin
			n = ins[11:7];
			case (ty)
				SHT_LSL: return (n == 0) ? {cin, rm} : {rm[32 - n], rm << n};
				SHT_LSR: return (n == 0) ? {rm[31], 32'h0} : {rm[n - 1], rm >> n};
				SHT_ASR: return (n == 0) ? {rm[31], {32{rm[31]}}}
						: {rm[n - 1], 32'($signed(rm) >>> n)};
				default: return (n == 0) ? {rm[0], cin, rm[31:1]} : {rm[n - 1], ror32(rm, n)};
			endcase
		end
		// shift by register, low byte only
		n = rs[7:0];
		if (n == 0)
			return {cin, rm};
		case (ty)
			SHT_LSL: begin
				if (n < 32) return {rm[32 - n], rm << n};
				return {(n == 32) ? rm[0] : 1'b0, 32'h0};
			end
			SHT_LSR: begin
				if (n < 32) return {rm[n - 1], rm >> n};
				return {(n == 32) ? rm[31] : 1'b0, 32'h0};
			end
			SHT_ASR: begin
				if (n < 32) return {rm[n - 1], 32'($signed(rm) >>> n)};
				return {rm[31], {32{rm[31]}}};
			end
			default: begin
				n = n % 32;
				if (n == 0) return {rm[31], rm};
				return {rm[n - 1], ror32(rm, n)};
			end
		endcase
	endfunction

	function automatic logic [31:0] add_flags(input logic [31:0] x, input logic [31:0] y,
			input logic ci, output logic c, output logic v);
		logic [32:0] sum;
		sum = {1'b0, x} + {1'b0, y} + {32'h0, ci};
		c = sum[32];
		v = (x[31] == y[31]) && (sum[31] != x[31]);
		return sum[31:0];
	endfunction

	function automatic dp_result_t execute_dp(dp_item_t it);
		dp_result_t  res;
		alu_op_t     op;
		logic [32:0] shop;
		logic [31:0] a, b, r;
		logic        cin, c, v, is_cmp, arith, sbit;
		res = '0;
		op = alu_op_t'(it.instr[24:21]);
		sbit = it.instr[20];
		is_cmp = op inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN};
		if ((it.instr[27:25] != CLS_REG && it.instr[27:25] != CLS_IMM) || (is_cmp && !sbit)) begin
			res.status = STAT_UNDEF;
			return res;
		end
		a = it.first_value;
		cin = it.flags_in[1];
		v = it.flags_in[0];
		c = 1'b0;
		arith = 1'b1;
		shop = barrel_shift(it.instr, it.shifted_value, it.amount_value, cin);
		b = shop[31:0];
		// ALU; reverse subtracts keep V on the real operand order
		case (op)
			OP_AND, OP_TST: begin r = a & b; arith = 1'b0; end
			OP_EOR, OP_TEQ: begin r = a ^ b; arith = 1'b0; end
			OP_SUB, OP_CMP: r = add_flags(a, ~b, 1'b1, c, v);
			OP_RSB:         r = add_flags(b, ~a, 1'b1, c, v);
			OP_ADD, OP_CMN: r = add_flags(a, b, 1'b0, c, v);
			OP_ADC:         r = add_flags(a, b, cin, c, v);
			OP_SBC:         r = add_flags(a, ~b, cin, c, v);
			OP_RSC:         r = add_flags(b, ~a, cin, c, v);
			OP_ORR:         begin r = a | b; arith = 1'b0; end
			OP_MOV:         begin r = b; arith = 1'b0; end
			OP_BIC:         begin r = a & ~b; arith = 1'b0; end
			default:        begin r = ~b; arith = 1'b0; end
		endcase
		if (!arith) begin
			c = shop[32];
			v = it.flags_in[0];
		end
		res.result_value = r;
		res.dest_index = it.instr[15:12];
		res.dest_write = !is_cmp;
		res.flags_out = {r[31], r == 32'h0, c, v};
		res.status = STAT_DONE;
		// S with PC as destination restores saved status instead of flags, or is unpredictable without one
		if (is_cmp)
			res.flags_write = 1'b1;
		else if (sbit) begin
			if (it.instr[15:12] == REG_PC) begin
				res.restore_status = it.has_saved_status;
				res.status = it.has_saved_status ? STAT_DONE : STAT_UNPRED;
			end else
				res.flags_write = 1'b1;
		end
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic logic [31:0] enc(logic [2:0] cls, alu_op_t op, logic s, logic [3:0] rd,
			logic [11:0] sh);
		return {4'hE, cls, op, s, 4'h1, rd, sh};
	endfunction

	function automatic logic [11:0] imm_shift(logic [4:0] amt, logic [1:0] ty);
		return {amt, ty, 1'b0, 4'h2};
	endfunction

	function automatic logic [11:0] reg_shift(logic [1:0] ty, logic b7);
		return {4'h3, b7, ty, 1'b1, 4'h2};
	endfunction

	function automatic void add_row(logic [31:0] ins, logic [31:0] a, logic [31:0] rm,
			logic [31:0] rs, logic [3:0] fl, logic saved, bit typed = 1'b0,
			dp_result_t want = '0);
		dir_row_t row;
		row.item = '{ins, a, rm, rs, fl, saved};
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 3);
			default: return $urandom();
		endcase
	endfunction

	// Mostly legal data-processing encodings with random content
	function automatic dp_item_t random_item();
		dp_item_t it;
		it.instr = $urandom();
		if ($urandom_range(0, 99) < 92)
			it.instr[27:25] = $urandom_range(0, 1) ? CLS_IMM : CLS_REG;
		if (it.instr[24:23] == 2'b10 && $urandom_range(0, 9) != 0)
			it.instr[20] = 1'b1;
		if ($urandom_range(0, 7) == 0)
			it.instr[15:12] = REG_PC;
		if ($urandom_range(0, 7) == 0)
			it.instr[11:7] = 5'd0;
		it.first_value = pick_word();
		it.shifted_value = pick_word();
		case ($urandom_range(0, 3))
			0: it.amount_value = $urandom_range(0, 40);
			1: it.amount_value = ($urandom() & 32'hFFFF_FF00) | $urandom_range(28, 36);
			default: it.amount_value = $urandom();
		endcase
		it.flags_in = $urandom_range(0, 15);
		it.has_saved_status = $urandom_range(0, 1);
		return it;
	endfunction

	// ------------------------------------------------------------------------
	// Driver
	// ------------------------------------------------------------------------

	// a 4% chance of an idle gap before each item gives about 7% idle time
	task automatic maybe_idle(input bit quiet);
		if (!quiet && $urandom_range(0, 99) < 4) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Present one item and hold it until the unit takes it
	task automatic send_item(input dp_item_t it, input dp_result_t want);
		start <= 1'b1;
		instr <= it.instr;
		first_value <= it.first_value;
		shifted_value <= it.shifted_value;
		amount_value <= it.amount_value;
		flags_in <= it.flags_in;
		has_saved_status <= it.has_saved_status;
		do @(posedge clk); while (busy_seen !== 1'b0);
		pending_results.push_back(want);
	endtask

	initial begin
		// wrong class and compares without S
		add_row(enc(3'b010, OP_ADD, 1'b1, 4'h1, 12'h000), '1, '1, '1, 4'hF, 1'b1, 1'b1, UNDEF_RESULT);
		add_row(32'hFFFF_FFFF, '1, '1, '1, 4'hF, 1'b1, 1'b1, UNDEF_RESULT);
		add_row(enc(CLS_REG, OP_CMP, 1'b0, 4'h0, imm_shift(5'd0, SHT_LSL)), 32'h5, 32'h5, 32'h0,
			4'h0, 1'b0, 1'b1, UNDEF_RESULT);
		add_row(enc(CLS_IMM, OP_TST, 1'b0, 4'h0, 12'h0FF), '1, 32'h0, 32'h0, 4'hF, 1'b0, 1'b1,
			UNDEF_RESULT);
		add_row(enc(CLS_IMM, OP_TEQ, 1'b0, 4'hF, 12'h0FF), '1, 32'h0, 32'h0, 4'h0, 1'b1, 1'b1,
			UNDEF_RESULT);
		add_row(enc(CLS_REG, OP_CMN, 1'b0, 4'h3, reg_shift(SHT_ROR, 1'b0)), '1, '1, 32'h4,
			4'h2, 1'b0, 1'b1, UNDEF_RESULT);
		// all ones plus one wraps to zero with carry
		add_row(enc(CLS_IMM, OP_ADD, 1'b1, 4'h1, 12'h001), 32'hFFFF_FFFF, 32'h0, 32'h0, 4'h0,
			1'b0, 1'b1, dp_result_t'{32'h0, 4'h1, 1'b1, 4'b0110, 1'b1, 1'b0, STAT_DONE});
		// S to PC without a saved status register
		add_row(enc(CLS_IMM, OP_MOV, 1'b1, REG_PC, 12'h000), 32'hFFFF_FFFF, 32'h0, 32'h0, 4'h0,
			1'b0, 1'b1, dp_result_t'{32'h0, REG_PC, 1'b1, 4'b0100, 1'b0, 1'b0, STAT_UNPRED});
		// immediate shift corners: LSL #0, LSR #32, ASR #32, RRX
		add_row(enc(CLS_REG, OP_AND, 1'b1, 4'h2, imm_shift(5'd0, SHT_LSL)), '1, 32'h8000_0001,
			32'h0, 4'b0010, 1'b1);
		add_row(enc(CLS_REG, OP_EOR, 1'b1, 4'h3, imm_shift(5'd0, SHT_LSR)), 32'h0, 32'h8000_0000,
			32'h0, 4'b0001, 1'b0);
		add_row(enc(CLS_REG, OP_SUB, 1'b1, 4'h4, imm_shift(5'd0, SHT_ASR)), 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0, 4'h0, 1'b0);
		add_row(enc(CLS_REG, OP_RSB, 1'b1, 4'h5, imm_shift(5'd0, SHT_ROR)), 32'h1, 32'h3, 32'h0,
			4'b0010, 1'b0);
		// reverse subtract overflow
		add_row(enc(CLS_REG, OP_RSB, 1'b1, 4'h6, imm_shift(5'd0, SHT_LSL)), 32'h1, 32'h8000_0000,
			32'h0, 4'h0, 1'b0);
		// rotated immediates
		add_row(enc(CLS_IMM, OP_ADD, 1'b1, 4'h7, 12'hFFF), 32'h1, 32'h0, 32'h0, 4'h0, 1'b0);
		add_row(enc(CLS_IMM, OP_ORR, 1'b1, 4'h8, 12'h4FF), 32'h0100_0000, 32'h0, 32'h0, 4'h0,
			1'b0);
		// register shifts: by 32, beyond 32, far beyond, multiple of 32, zero low byte
		add_row(enc(CLS_REG, OP_ADC, 1'b1, 4'h9, reg_shift(SHT_LSL, 1'b0)), 32'h1, 32'h1,
			32'h20, 4'b0010, 1'b0);
		add_row(enc(CLS_REG, OP_SBC, 1'b1, 4'hA, reg_shift(SHT_LSR, 1'b0)), 32'h0, '1, 32'h21,
			4'h0, 1'b0);
		add_row(enc(CLS_REG, OP_RSC, 1'b1, 4'hB, reg_shift(SHT_ASR, 1'b0)), 32'h0, 32'h8000_0000,
			32'hC8, 4'b0010, 1'b0);
		add_row(enc(CLS_REG, OP_TST, 1'b1, 4'hC, reg_shift(SHT_ROR, 1'b0)), '1, 32'h8000_0001,
			32'h40, 4'b0001, 1'b0);
		add_row(enc(CLS_REG, OP_TEQ, 1'b1, 4'hD, reg_shift(SHT_LSL, 1'b0)), 32'h1234_5678,
			32'h1234_5678, 32'hFFFF_FF00, 4'b0010, 1'b0);
		// compare with PC destination still writes flags
		add_row(enc(CLS_REG, OP_CMP, 1'b1, REG_PC, imm_shift(5'd0, SHT_LSL)), 32'h5, 32'h5,
			32'h0, 4'h0, 1'b0);
		add_row(enc(CLS_REG, OP_CMN, 1'b1, 4'hE, reg_shift(SHT_LSR, 1'b0)), '1, '1, 32'h1F,
			4'h0, 1'b1);
		// MOV ignores first_value; bit 7 set on a register shift
		add_row(enc(CLS_REG, OP_MOV, 1'b1, 4'h0, reg_shift(SHT_ASR, 1'b1)), '1, 32'hF000_0000,
			32'h4, 4'h0, 1'b0);
		add_row(enc(CLS_REG, OP_BIC, 1'b0, 4'h1, imm_shift(5'd31, SHT_ROR)), '1, 32'h1, 32'h0,
			4'hF, 1'b0);
		// S to PC with a saved status register
		add_row(enc(CLS_IMM, OP_MVN, 1'b1, REG_PC, 12'h0FF), '1, 32'h0, 32'h0, 4'hF, 1'b1);
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		dp_item_t it;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			maybe_idle(1'b0);
			send_item(directed_rows[i].item,
				directed_rows[i].typed ? directed_rows[i].want : execute_dp(directed_rows[i].item));
		end

		// random stream, a back-to-back stretch in the middle
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			maybe_idle(i >= 300 && i < 450);
			it = random_item();
			send_item(it, execute_dp(it));
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("** shifter_alu_execute_top: PASSED **");
		else
			$display("** shifter_alu_execute_top: FAILED **");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
		$display("** shifter_alu_execute_top: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result checking, sampled mid-cycle
	// ------------------------------------------------------------------------

	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, fname, want, got);
			mismatch_count++;
		end
	endtask

	always @(negedge clk)
		busy_seen = busy;

	always @(negedge clk) begin
		dp_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no item outstanding: expected none, got %h", $time,
					result_value);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("result_value", want.result_value, result_value);
				check_field("dest_index", 32'(want.dest_index), 32'(dest_index));
				check_field("dest_write", 32'(want.dest_write), 32'(dest_write));
				check_field("flags_out", 32'(want.flags_out), 32'(flags_out));
				check_field("flags_write", 32'(want.flags_write), 32'(flags_write));
				check_field("restore_status", 32'(want.restore_status), 32'(restore_status));
				check_field("status", 32'(want.status), 32'(status));
			end
		end
	end

endmodule
